>>> hdl/prl_pkg.sv
// Package for the positional record list: sizes, command kinds and the
// types shared by the cells, the group pickers and the top level.
// Depends on nothing.
package prl_pkg;

  localparam int CAPACITY   = 128;
  localparam int KEY_BITS   = 64;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Cells are gathered in groups whose first hit is picked combinationally and registered.
  localparam int GROUP_SIZE     = 16;
  localparam int LOCAL_BITS     = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GROUP_IDX_BITS = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_INSERT    = 3'd1;
  localparam logic [2:0] KIND_REMOVE    = 3'd2;
  localparam logic [2:0] KIND_FIND_ID   = 3'd3;
  localparam logic [2:0] KIND_FIND_NAME = 3'd4;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    key_t id;
    key_t name;
  } record_t;

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_LOAD,
    EDIT_INSERT,
    EDIT_REMOVE
  } edit_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    edit_t                 edit;
    logic [IDX_BITS-1:0]   target;
    logic                  search;
    logic                  by_name;
    logic [COUNT_BITS-1:0] count;
    record_t               rec;
  } cell_cmd_t;

  typedef struct packed {
    logic                  any;
    logic [LOCAL_BITS-1:0] slot;
    record_t               rec;
  } group_res_t;

endpackage

>>> hdl/prl_cell.sv
// One cell of the record chain: holds one record and its search hit bit.
// Depends on prl_pkg.
module prl_cell
  import prl_pkg::*;
(
  input  logic                clk,
  input  logic [IDX_BITS-1:0] index,
  input  cell_cmd_t           cmd,
  input  record_t             prev_rec,
  input  record_t             next_rec,
  output record_t             rec,
  output logic                hit
);

  logic in_use;

  assign in_use = COUNT_BITS'(index) < cmd.count;

  always_ff @(posedge clk) begin
    unique case (cmd.edit)
      EDIT_LOAD: begin
        if (index == cmd.target) rec <= cmd.rec;
      end
      EDIT_INSERT: begin
        if (index == cmd.target) rec <= cmd.rec;
        else if (index > cmd.target) rec <= prev_rec;
      end
      EDIT_REMOVE: begin
        if (index >= cmd.target) rec <= next_rec;
      end
      default: begin
      end
    endcase
    if (cmd.search) begin
      hit <= in_use && (cmd.by_name ? (rec.name == cmd.rec.name) : (rec.id == cmd.rec.id));
    end
  end

endmodule

>>> hdl/prl_group.sv
// Picks the first hit within one group of cells and registers its slot and record.
// Depends on prl_pkg.
module prl_group
  import prl_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic [GROUP_SIZE-1:0] hits,
  input  record_t               recs [GROUP_SIZE],
  output group_res_t            res
);

  group_res_t res_next;

  always_comb begin
    res_next.any  = |hits;
    res_next.slot = '0;
    res_next.rec  = recs[0];
    for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
      if (hits[j]) begin
        res_next.slot = LOCAL_BITS'(j);
        res_next.rec  = recs[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

endmodule

>>> hdl/positional_record_list_top.sv
// Top level of the positional record list: command decode, record chain,
// group pickers, group scan and the reply register.
// Depends on prl_pkg, prl_cell and prl_group.
//
// The block keeps an ordered list of up to CAPACITY records, each an id key
// and a name key. A command word arrives on the cmd channel (kind, position,
// id_key, name_key) and is accepted at a rising edge with cmd_valid high and
// cmd_stall low. Every command gives exactly one reply word on the reply
// channel (status, found_position, found_id, found_name, entry_count), taken
// at an edge with reply_valid high and reply_stall low.
// One command is worked on at a time. Append, insert, remove and unused kinds
// pass through the execute state, which updates every cell of the chain at
// once and loads the reply register; the block then returns to idle, where
// the next command may be accepted. A find passes through the execute state,
// where every cell registers its hit, the gather state, where each group of
// GROUP_SIZE cells registers its first hit, and the scan state, which steps
// one group a cycle over the registered group results to the first hit or the last group.
// While the receiver stalls, the reply word holds still and a further command
// is still accepted; its reply waits inside the block until the register is
// free, and no command is accepted meanwhile.
// Synchronous reset empties the list and drops any reply word; record contents
// are not cleared, as only records below the entry count are ever read.
module positional_record_list_top
  import prl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  position,
  input  logic [63:0] id_key,
  input  logic [63:0] name_key,
  output logic        reply_valid,
  input  logic        reply_stall,
  output logic        status,
  output logic [7:0]  found_position,
  output logic [63:0] found_id,
  output logic [63:0] found_name,
  output logic [7:0]  entry_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // Width that holds both an 8-bit position and the entry count, plus a carry.
  localparam int CMP_BITS = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

  state_t state;

  // Command register, loaded at acceptance. Keys are already cut to KEY_BITS.
  logic [2:0] cmd_kind;
  logic [7:0] cmd_pos;
  record_t    cmd_rec;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  logic [GROUP_IDX_BITS-1:0] scan_group;

  // Reply waiting for the reply register while the receiver stalls.
  logic                  hold_status;
  logic [COUNT_BITS-1:0] hold_pos;
  record_t               hold_rec;

  cell_cmd_t  cell_cmd;
  record_t    cell_rec [CAPACITY];
  logic       cell_hit [CAPACITY];
  group_res_t group_res [NUM_GROUPS];

  logic [CMP_BITS-1:0] pos_w;
  logic [CMP_BITS-1:0] cnt_w;
  logic                insert_ok;
  logic                remove_ok;
  logic                append_ok;
  logic                is_find;

  group_res_t scan_res;
  logic       scan_last;

  logic                  done;
  logic                  done_status;
  logic [COUNT_BITS-1:0] done_pos;
  record_t               done_rec;
  logic [COUNT_BITS-1:0] done_count;
  logic                  reply_free;

  assign cmd_stall  = (state != ST_IDLE);
  assign reply_free = !reply_valid || !reply_stall;

  // Range checks on the command held in the register.
  assign pos_w     = CMP_BITS'(cmd_pos);
  assign cnt_w     = CMP_BITS'(count);
  assign append_ok = cnt_w < CMP_BITS'(CAPACITY);
  assign insert_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1) && append_ok;
  assign remove_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign is_find   = (cmd_kind == KIND_FIND_ID) || (cmd_kind == KIND_FIND_NAME);

  // Command broadcast to the chain. Edits only act in the execute cycle.
  always_comb begin
    cell_cmd.edit    = EDIT_NONE;
    cell_cmd.target  = IDX_BITS'(pos_w - 1'b1);
    cell_cmd.search  = (state == ST_EXEC) && is_find;
    cell_cmd.by_name = (cmd_kind == KIND_FIND_NAME);
    cell_cmd.count   = count;
    cell_cmd.rec     = cmd_rec;
    count_next       = count;
    if (state == ST_EXEC) begin
      priority if (cmd_kind == KIND_APPEND && append_ok) begin
        cell_cmd.edit   = EDIT_LOAD;
        cell_cmd.target = IDX_BITS'(count);
        count_next      = count + 1'b1;
      end else if (cmd_kind == KIND_INSERT && insert_ok) begin
        cell_cmd.edit = EDIT_INSERT;
        count_next    = count + 1'b1;
      end else if (cmd_kind == KIND_REMOVE && remove_ok) begin
        cell_cmd.edit = EDIT_REMOVE;
        count_next    = count - 1'b1;
      end else begin
      end
    end
  end

  // The chain itself. Each cell sees both neighbours for the shifts.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    record_t prev_rec;
    record_t next_rec;
    if (i == 0) begin : g_first
      assign prev_rec = '0;
    end else begin : g_mid_prev
      assign prev_rec = cell_rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_rec = cell_rec[i];
    end else begin : g_mid_next
      assign next_rec = cell_rec[i+1];
    end
    prl_cell u_cell (
      .clk      (clk),
      .index    (IDX_BITS'(i)),
      .cmd      (cell_cmd),
      .prev_rec (prev_rec),
      .next_rec (next_rec),
      .rec      (cell_rec[i]),
      .hit      (cell_hit[i])
    );
  end

  // Group pickers; a short last group is padded with cells that never hit.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    logic [GROUP_SIZE-1:0] grp_hits;
    record_t               grp_recs [GROUP_SIZE];
    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_slot
      if (g * GROUP_SIZE + j < CAPACITY) begin : g_real
        assign grp_hits[j] = cell_hit[g*GROUP_SIZE+j];
        assign grp_recs[j] = cell_rec[g*GROUP_SIZE+j];
      end else begin : g_pad
        assign grp_hits[j] = 1'b0;
        assign grp_recs[j] = '0;
      end
    end
    prl_group u_group (
      .clk  (clk),
      .load (state == ST_GATHER),
      .hits (grp_hits),
      .recs (grp_recs),
      .res  (group_res[g])
    );
  end

  assign scan_res  = group_res[scan_group];
  assign scan_last = (scan_group == GROUP_IDX_BITS'(NUM_GROUPS - 1));

  // The reply that is ready this cycle, if any.
  always_comb begin
    done        = 1'b0;
    done_status = 1'b1;
    done_pos    = '0;
    done_rec    = '0;
    done_count  = count;
    unique case (state)
      ST_EXEC: begin
        done        = !is_find;
        done_status = (cell_cmd.edit == EDIT_NONE);
        done_count  = count_next;
      end
      ST_SCAN: begin
        done = scan_res.any || scan_last;
        if (scan_res.any) begin
          done_status = 1'b0;
          done_pos    = COUNT_BITS'({scan_group, scan_res.slot}) + 1'b1;
          done_rec    = scan_res.rec;
        end
      end
      ST_HOLD: begin
        done        = 1'b1;
        done_status = hold_status;
        done_pos    = hold_pos;
        done_rec    = hold_rec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      reply_valid <= 1'b0;
      scan_group  <= '0;
    end else begin
      count <= count_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_kind     <= kind;
            cmd_pos      <= position;
            cmd_rec.id   <= id_key[KEY_BITS-1:0];
            cmd_rec.name <= name_key[KEY_BITS-1:0];
            state        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          scan_group <= '0;
          if (is_find) state <= ST_GATHER;
        end
        ST_GATHER: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!done) scan_group <= scan_group + 1'b1;
        end
        ST_HOLD: begin
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (done && reply_free) begin
        reply_valid    <= 1'b1;
        status         <= done_status;
        found_position <= 8'(done_pos);
        found_id       <= 64'(done_rec.id);
        found_name     <= 64'(done_rec.name);
        entry_count    <= 8'(done_count);
        state          <= ST_IDLE;
      end else begin
        if (reply_valid && !reply_stall) reply_valid <= 1'b0;
        if (done) begin
          hold_status <= done_status;
          hold_pos    <= done_pos;
          hold_rec    <= done_rec;
          state       <= ST_HOLD;
        end
      end
    end
  end

  // A stalled reply word is never overwritten.
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_stall |=> reply_valid && $stable(status) && $stable(found_id)
      && $stable(entry_count))
    else $error("reply word changed while stalled");

  // Each command moves the entry count by at most one.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + 1'b1)
      || (count + 1'b1 == $past(count)))
    else $error("entry count jumped");

  // The list never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst)
    (COUNT_BITS + 1)'(count) <= (COUNT_BITS + 1)'(CAPACITY))
    else $error("entry count above capacity");

  // A failed reply (status high) carries no position and no id.
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && status |-> (found_position == '0) && (found_id == '0))
    else $error("rejected reply carries a match");

  // An accepted command blocks the next one: the command channel stalls right after acceptance.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while another was in progress");

endmodule
